/* src/ohi_pkg.sv */
// Shared constants, types and codes of the open-addressing hash insert block
`default_nettype none
package ohi_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int N_W         = SLOT_W + 1;
	localparam int CFG_TS_W    = 11;
	localparam int NC_W        = (N_W > CFG_TS_W) ? N_W : CFG_TS_W;
	localparam int KEY_W       = 31;
	localparam int ENTRY_W     = KEY_W + 1;
	localparam int DIV_CNT_W   = $clog2(KEY_W);
	localparam int OP_W        = 2;
	localparam int MODE_W      = 2;
	localparam int PRIME_W     = 10;
	localparam int SLOT_FLD_W  = 10;
	localparam int COLL_W      = 11;
	localparam int TOTAL_W     = 32;
	localparam int VALUE_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_PRIME = 2'd2;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CLEAR, S_BASE_GO, S_BASE_WAIT, S_KR_GO, S_KR_WAIT,
		S_INC_GO, S_INC_WAIT, S_PINIT, S_PRD, S_PCHK, S_READ_RD, S_RESP
	} state_t;

	typedef enum logic [1:0] {
		DIV_BASE, DIV_KR, DIV_INC
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     sweep;
		logic     div_start;
		logic     div_take;
		div_sel_t div_sel;
		logic     probe_init;
		logic     probe_rd;
		logic     place;
		logic     probe_next;
		logic     read_rd;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic div_done;
		logic slot_full;
		logic probe_last;
		logic mode_double;
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

/* src/ohi_in_if.sv */
// Input item channel
`default_nettype none
interface ohi_in_if;
	import ohi_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [KEY_W-1:0]  key;
	logic [SLOT_FLD_W-1:0] read_slot;
	modport source(output valid, operation, key, read_slot, input ready);
	modport sink(input valid, operation, key, read_slot, output ready);
endinterface
`default_nettype wire

/* src/ohi_out_if.sv */
// Result item channel
`default_nettype none
interface ohi_out_if;
	import ohi_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [SLOT_FLD_W-1:0]    slot;
	logic                     placed;
	logic [COLL_W-1:0]        insert_collisions;
	logic [TOTAL_W-1:0]       collision_total;
	logic signed [VALUE_W-1:0] read_value;
	modport source(output valid, slot, placed, insert_collisions, collision_total,
		read_value, input ready);
	modport sink(input valid, slot, placed, insert_collisions, collision_total,
		read_value, output ready);
endinterface
`default_nettype wire

/* src/ohi_cfg_if.sv */
// Configuration write channel
`default_nettype none
interface ohi_cfg_if;
	import ohi_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/ohi_ram.sv */
// Generic single-port RAM with registered read
`default_nettype none
module ohi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule
`default_nettype wire

/* src/ohi_div.sv */
// Bit-serial remainder unit, one dividend bit per cycle
`default_nettype none
module ohi_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [ohi_pkg::KEY_W-1:0] dividend,
	input  wire logic [ohi_pkg::NC_W-1:0]  divisor,
	output logic                          done,
	output logic      [ohi_pkg::NC_W-1:0]  rem
);
	import ohi_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0]     a_q;
	logic [NC_W-1:0]      b_q;
	logic [NC_W-1:0]      rem_q;
	logic [NC_W:0]        trial;

	always_comb begin
		trial = {rem_q, a_q[KEY_W-1]};
		if (trial >= {1'b0, b_q}) begin
			trial = trial - {1'b0, b_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(KEY_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= dividend;
			b_q   <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[KEY_W-2:0], 1'b0};
			rem_q <= trial[NC_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

/* src/ohi_ctrl.sv */
// Controller state machine sequencing clear, insert probing and read
`default_nettype none
module ohi_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic [ohi_pkg::OP_W-1:0] in_op,
	input  wire ohi_pkg::status_t        st,
	output logic                        in_ready,
	output ohi_pkg::cmd_t                cmd
);
	import ohi_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (st.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					case (in_op)
						OP_CLEAR:  state_d = S_CLEAR;
						OP_INSERT: state_d = S_BASE_GO;
						OP_READ:   state_d = S_READ_RD;
						default:   state_d = S_RESP;
					endcase
				end
			end
			S_CLEAR: begin
				if (st.sweep_last) state_d = S_RESP;
			end
			S_BASE_GO:   state_d = S_BASE_WAIT;
			S_BASE_WAIT: begin
				if (st.div_done) state_d = st.mode_double ? S_KR_GO : S_PINIT;
			end
			S_KR_GO:     state_d = S_KR_WAIT;
			S_KR_WAIT: begin
				if (st.div_done) state_d = S_INC_GO;
			end
			S_INC_GO:    state_d = S_INC_WAIT;
			S_INC_WAIT: begin
				if (st.div_done) state_d = S_PINIT;
			end
			S_PINIT:     state_d = S_PRD;
			S_PRD:       state_d = S_PCHK;
			S_PCHK: begin
				if (!st.slot_full || st.probe_last) state_d = S_RESP;
				else state_d = S_PRD;
			end
			S_READ_RD:   state_d = S_RESP;
			S_RESP: begin
				if (!st.out_busy) state_d = S_IDLE;
			end
			default:     state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.div_sel = DIV_BASE;
		in_ready = 1'b0;
		case (state_q)
			S_INIT, S_CLEAR: cmd.sweep = 1'b1;
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_BASE_GO: cmd.div_start = 1'b1;
			S_BASE_WAIT: cmd.div_take = 1'b1;
			S_KR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_KR;
			end
			S_KR_WAIT: begin
				cmd.div_take = 1'b1;
				cmd.div_sel  = DIV_KR;
			end
			S_INC_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_INC;
			end
			S_INC_WAIT: begin
				cmd.div_take = 1'b1;
				cmd.div_sel  = DIV_INC;
			end
			S_PINIT: cmd.probe_init = 1'b1;
			S_PRD:   cmd.probe_rd = 1'b1;
			S_PCHK: begin
				cmd.place      = !st.slot_full;
				cmd.probe_next = st.slot_full;
			end
			S_READ_RD: cmd.read_rd = 1'b1;
			S_RESP:    cmd.load_out = !st.out_busy;
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule
`default_nettype wire

/* src/ohi_dp.sv */
// Datapath: configuration, slot memory, probe arithmetic and result register
`default_nettype none
module ohi_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ohi_pkg::cmd_t                cmd,
	output ohi_pkg::status_t                  st,
	input  wire logic [ohi_pkg::OP_W-1:0]     in_op,
	input  wire logic [ohi_pkg::KEY_W-1:0]    in_key,
	input  wire logic [ohi_pkg::SLOT_FLD_W-1:0] in_read_slot,
	ohi_cfg_if.sink                          cfg_ch,
	ohi_out_if.source                        out_ch
);
	import ohi_pkg::*;

	logic [CFG_TS_W-1:0]   ts_q;
	logic [MODE_W-1:0]     mode_q;
	logic [PRIME_W-1:0]    prime_q;
	logic [OP_W-1:0]       op_q;
	logic [KEY_W-1:0]      key_q;
	logic [SLOT_FLD_W-1:0] rs_q;
	logic [SLOT_W-1:0]     sweep_q;
	logic [SLOT_W-1:0]     base_q;
	logic [PRIME_W-1:0]    h_q;
	logic [SLOT_W-1:0]     inc_q;
	logic [SLOT_W-1:0]     s_q;
	logic [N_W-1:0]        i_q;
	logic [N_W-1:0]        hits_q;
	logic                  placed_q;
	logic [TOTAL_W-1:0]    total_q;
	logic                  out_valid_q;

	logic [NC_W-1:0]       ts_ext;
	logic [NC_W-1:0]       n_nc;
	logic [N_W-1:0]        n;
	logic [PRIME_W-1:0]    r_eff;
	logic [KEY_W-1:0]      div_a;
	logic [NC_W-1:0]       div_b;
	logic                  div_done;
	logic [NC_W-1:0]       div_rem;
	logic [N_W-1:0]        s_sum;
	logic [N_W-1:0]        d_sum;
	logic [TOTAL_W:0]      tot_sum;
	logic [TOTAL_W-1:0]    tot_next;
	logic                  ram_we;
	logic                  ram_re;
	logic [SLOT_W-1:0]     ram_addr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [ENTRY_W-1:0]    ram_rdata;
	logic                  rd_oob;
	logic [SLOT_FLD_W-1:0] res_slot;
	logic                  res_placed;
	logic [COLL_W-1:0]     res_coll;
	logic [VALUE_W-1:0]    res_value;

	assign ts_ext = NC_W'(ts_q);
	always_comb begin
		if (ts_q == '0) n_nc = NC_W'(1);
		else if (ts_ext > NC_W'(TABLE_DEPTH)) n_nc = NC_W'(TABLE_DEPTH);
		else n_nc = ts_ext;
	end
	assign n     = N_W'(n_nc);
	assign r_eff = (prime_q == '0) ? PRIME_W'(1) : prime_q;

	always_comb begin
		case (cmd.div_sel)
			DIV_KR: begin
				div_a = key_q;
				div_b = NC_W'(r_eff);
			end
			DIV_INC: begin
				div_a = KEY_W'(h_q);
				div_b = n_nc;
			end
			default: begin
				div_a = key_q;
				div_b = n_nc;
			end
		endcase
	end

	ohi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		s_sum = N_W'(s_q) + N_W'(inc_q);
		if (s_sum >= n) s_sum = s_sum - n;
		d_sum = N_W'(inc_q) + N_W'(2);
		if (d_sum >= n) d_sum = d_sum - n;
		if (d_sum >= n) d_sum = d_sum - n;
	end

	always_comb begin
		ram_we    = cmd.sweep || cmd.place;
		ram_re    = cmd.probe_rd || cmd.read_rd;
		ram_wdata = cmd.sweep ? '0 : {1'b1, key_q};
		if (cmd.sweep) ram_addr = sweep_q;
		else if (cmd.read_rd) ram_addr = SLOT_W'(rs_q);
		else ram_addr = s_q;
	end

	ohi_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign rd_oob   = (32'(rs_q) >= 32'(TABLE_DEPTH));
	assign tot_sum  = {1'b0, total_q} + (TOTAL_W+1)'(hits_q);
	assign tot_next = (op_q != OP_INSERT) ? total_q :
		(tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0]);

	always_comb begin
		res_slot   = '0;
		res_placed = 1'b0;
		res_coll   = '0;
		res_value  = '0;
		case (op_q)
			OP_INSERT: begin
				res_slot   = placed_q ? SLOT_FLD_W'(s_q) : '0;
				res_placed = placed_q;
				res_coll   = COLL_W'(hits_q);
			end
			OP_READ: begin
				res_slot  = rs_q;
				res_value = (rd_oob || !ram_rdata[KEY_W]) ? '1 :
					VALUE_W'(ram_rdata[KEY_W-1:0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q        <= CFG_TS_W'(1024);
			mode_q      <= MODE_LINEAR;
			prime_q     <= PRIME_W'(1021);
			sweep_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					REG_TABLE_SIZE:   ts_q    <= cfg_ch.data[CFG_TS_W-1:0];
					REG_PROBE_MODE:   mode_q  <= cfg_ch.data[MODE_W-1:0];
					REG_SECOND_PRIME: prime_q <= cfg_ch.data[PRIME_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.sweep) sweep_q <= sweep_q + 1'b1;
			if (cmd.capture && in_op == OP_CLEAR) total_q <= '0;
			else if (cmd.load_out) total_q <= tot_next;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_op;
			key_q <= in_key;
			rs_q  <= in_read_slot;
		end
		if (cmd.div_take && div_done) begin
			case (cmd.div_sel)
				DIV_KR:  h_q    <= r_eff - PRIME_W'(div_rem);
				DIV_INC: inc_q  <= SLOT_W'(div_rem);
				default: base_q <= SLOT_W'(div_rem);
			endcase
		end
		if (cmd.probe_init) begin
			s_q      <= base_q;
			i_q      <= '0;
			hits_q   <= '0;
			placed_q <= 1'b0;
			if (mode_q != MODE_DOUBLE) inc_q <= (n == N_W'(1)) ? '0 : SLOT_W'(1);
		end
		if (cmd.probe_next) begin
			s_q    <= SLOT_W'(s_sum);
			i_q    <= i_q + 1'b1;
			hits_q <= hits_q + 1'b1;
			if (mode_q == MODE_QUAD) inc_q <= SLOT_W'(d_sum);
		end
		if (cmd.place) placed_q <= 1'b1;
		if (cmd.load_out) begin
			out_ch.collision_total   <= tot_next;
			out_ch.slot              <= res_slot;
			out_ch.placed            <= res_placed;
			out_ch.insert_collisions <= res_coll;
			out_ch.read_value        <= res_value;
		end
	end

	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;

	assign st.sweep_last  = (sweep_q == SLOT_W'(TABLE_DEPTH - 1));
	assign st.div_done    = div_done;
	assign st.slot_full   = ram_rdata[KEY_W];
	assign st.probe_last  = (i_q == n - 1'b1);
	assign st.mode_double = (mode_q == MODE_DOUBLE);
	assign st.out_busy    = out_valid_q && !out_ch.ready;
endmodule
`default_nettype wire

/* src/open_addressing_hash_insert.sv */
// Top level of the open-addressing hash table insert block
// One item is processed at a time; a finished result waits in an output register while the next
// item is taken. After reset the table is swept empty, during which no item is taken; a clear item
// does the same sweep. An insert first reduces the key modulo the table size in a bit-serial
// remainder unit, and in double hashing runs two more reductions (key mod prime, then the step
// mod table size), then probes the single-port slot memory, each probe a read followed by a
// check and write. Configuration writes are taken in any cycle.
`default_nettype none
module open_addressing_hash_insert (
	input  wire logic clk,
	input  wire logic arst_n,
	ohi_in_if.sink    in_ch,
	ohi_out_if.source out_ch,
	ohi_cfg_if.sink   cfg_ch
);
	import ohi_pkg::*;

	cmd_t    cmd;
	status_t st;

	ohi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.operation),
		.st       (st),
		.in_ready (in_ch.ready),
		.cmd      (cmd)
	);

	ohi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.in_op        (in_ch.operation),
		.in_key       (in_ch.key),
		.in_read_slot (in_ch.read_slot),
		.cfg_ch       (cfg_ch),
		.out_ch       (out_ch)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("item taken while previous one in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_ch.valid || out_ch.ready))
		else $error("pending result overwritten");

	a_place_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |-> !st.slot_full && !cmd.probe_next)
		else $error("key written into occupied slot");
endmodule
`default_nettype wire
